@@ hw/rtl/dlz_pkg.sv @@
// Shared constants and types for the descrambling LZSS decoder.
// No dependencies; used by dlz_unscramble and descramble_lzss_decoder.
package dlz_pkg;

  localparam int unsigned WIN_DEPTH = 2048;
  localparam int unsigned WIN_AW    = $clog2(WIN_DEPTH);

  // Write position after reset and after each end of stream
  localparam logic [WIN_AW-1:0] START_POS = WIN_AW'(2015);

  localparam logic [7:0] SCRAMBLE_BIAS = 8'h7c;

  // Length field of a reference is biased by two
  localparam logic [5:0] COPY_BIAS = 6'd2;

  typedef enum logic [1:0] {
    PH_FLAG,
    PH_LIT,
    PH_OFS_LO,
    PH_OFS_HI
  } phase_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LIT,
    ST_RD,
    ST_EMIT,
    ST_END
  } state_e;

  typedef struct packed {
    logic [7:0] data;
    logic       byte_valid;
    logic       last_of_run;
    logic       end_of_stream;
  } result_t;

endpackage

@@ hw/rtl/dlz_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dlz_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/dlz_unscramble.sv @@
// Key-derived unscrambler: holds the xor byte and rotate amount taken from the key.
// Depends on dlz_pkg.
module dlz_unscramble (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_key_i,
  input  logic [7:0]  byte_i,
  output logic [7:0]  byte_o
);
  import dlz_pkg::*;

  logic [7:0]  xor_q, xor_d;
  logic [2:0]  rot_q, rot_d;
  logic [11:0] key_hi;
  logic [5:0]  nib_sum;
  logic [4:0]  fold;
  logic [4:0]  rem5;
  logic [7:0]  mixed;

  // key[31:20] mod 5: 16 == 1 (mod 5), so nibbles add up
  always_comb begin
    key_hi  = cfg_key_i[31:20];
    nib_sum = {2'b00, key_hi[11:8]} + {2'b00, key_hi[7:4]} + {2'b00, key_hi[3:0]};
    fold    = {3'b000, nib_sum[5:4]} + {1'b0, nib_sum[3:0]};
    if (fold >= 5'd15) begin
      rem5 = fold - 5'd15;
    end else if (fold >= 5'd10) begin
      rem5 = fold - 5'd10;
    end else if (fold >= 5'd5) begin
      rem5 = fold - 5'd5;
    end else begin
      rem5 = fold;
    end
    rot_d = rem5[2:0] + 3'd1;
    xor_d = cfg_key_i[31:24] + cfg_key_i[10:3];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xor_q <= 8'h00;
      rot_q <= 3'd1;
    end else if (cfg_we_i) begin
      xor_q <= xor_d;
      rot_q <= rot_d;
    end
  end

  always_comb begin
    mixed = (byte_i - SCRAMBLE_BIAS) ^ xor_q;
    case (rot_q)
      3'd1:    byte_o = {mixed[0],   mixed[7:1]};
      3'd2:    byte_o = {mixed[1:0], mixed[7:2]};
      3'd3:    byte_o = {mixed[2:0], mixed[7:3]};
      3'd4:    byte_o = {mixed[3:0], mixed[7:4]};
      3'd5:    byte_o = {mixed[4:0], mixed[7:5]};
      default: byte_o = mixed;
    endcase
  end

endmodule

@@ hw/rtl/descramble_lzss_decoder.sv @@
// Descrambling LZSS decoder top level: token sequencer, history window, output register.
// Depends on dlz_pkg, dlz_ram and dlz_unscramble.
//
// Usage:
//   cfg channel (cfg_valid_i/cfg_ready_o, cfg_key_i) writes the 32-bit key; it is
//   always ready and the new key applies from the next accepted input item.
//   in channel takes one scrambled byte per item, last_byte_i marks the stream end.
//   out channel gives decoded bytes; a bare end marker has byte_valid_o low.
// Sequencing:
//   A flag byte or reference low byte is taken with no result unless it is marked last.
//   A literal is taken, then emitted from ST_LIT. A reference copies 2 to 33
//   bytes: each copied byte is one read and one write on the single
//   window RAM, read then write, so overlapped copies see fresh data.
//   After reset, and after every item marked last, a clearing pass writes zero
//   to all 2048 window entries, one per cycle; no input item is taken then.
// Stalls:
//   Results pass through a one-entry output register. While the receiver
//   holds off, flag and reference low bytes are still taken; the sequencer
//   waits on the next literal or copied byte and in_ready_o stays low until
//   the register drains.
module descramble_lzss_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [31:0] cfg_key_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       last_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       byte_valid_o,
  output logic       last_of_run_o,
  output logic       end_of_stream_o
);
  import dlz_pkg::*;

  state_e            state_q, state_d;
  phase_e            phase_q, phase_d;
  logic [WIN_AW-1:0] wp_q, wp_d;
  logic [WIN_AW-1:0] clr_q, clr_d;
  logic [WIN_AW-1:0] src_q, src_d;
  logic [8:0]        fs_q, fs_d;
  logic [8:0]        fs_shift;
  phase_e            nt_phase;
  logic [7:0]        ofs_lo_q, ofs_lo_d;
  logic [7:0]        lit_q, lit_d;
  logic [5:0]        cnt_q, cnt_d;
  logic              last_q, last_d;
  logic              out_valid_q, out_valid_d;
  result_t           res_q, res_d;
  logic              emit;
  logic              out_free;
  logic              tok_done;
  logic [7:0]        ub;

  logic              ram_we;
  logic [WIN_AW-1:0] ram_waddr;
  logic [7:0]        ram_wdata;
  logic              ram_re;
  logic [7:0]        ram_rdata;

  assign cfg_ready_o = 1'b1;

  dlz_unscramble u_unscramble (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_valid_i & cfg_ready_o),
    .cfg_key_i (cfg_key_i),
    .byte_i    (in_byte_i),
    .byte_o    (ub)
  );

  dlz_ram #(
    .Width (8),
    .Depth (WIN_DEPTH)
  ) u_window (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (src_q),
    .rdata_o (ram_rdata)
  );

  assign out_free = !out_valid_q || out_ready_i;

  // Consume one flag bit
  always_comb begin
    fs_shift = fs_q >> 1;
    if (fs_shift <= 9'd1) begin
      nt_phase = PH_FLAG;
    end else if (fs_shift[0]) begin
      nt_phase = PH_LIT;
    end else begin
      nt_phase = PH_OFS_LO;
    end
  end

  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    wp_d       = wp_q;
    clr_d      = clr_q;
    src_d      = src_q;
    fs_d       = fs_q;
    ofs_lo_d   = ofs_lo_q;
    lit_d      = lit_q;
    cnt_d      = cnt_q;
    last_d     = last_q;
    res_d      = res_q;
    emit       = 1'b0;
    tok_done   = 1'b0;
    in_ready_o = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = wp_q;
    ram_wdata  = 8'h00;
    ram_re     = 1'b0;

    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        clr_d     = clr_q + 1'b1;
        if (clr_q == '1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          last_d = last_byte_i;
          case (phase_q)
            PH_FLAG: begin
              fs_d    = {1'b1, ub};
              phase_d = ub[0] ? PH_LIT : PH_OFS_LO;
              if (last_byte_i) begin
                state_d = ST_END;
              end
            end
            PH_LIT: begin
              lit_d   = ub;
              state_d = ST_LIT;
            end
            PH_OFS_LO: begin
              ofs_lo_d = ub;
              phase_d  = PH_OFS_HI;
              if (last_byte_i) begin
                state_d = ST_END;
              end
            end
            PH_OFS_HI: begin
              src_d   = {ub[7:5], ofs_lo_q};
              cnt_d   = {1'b0, ub[4:0]} + COPY_BIAS;
              state_d = ST_RD;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_LIT: begin
        if (out_free) begin
          emit      = 1'b1;
          res_d     = '{data: lit_q, byte_valid: 1'b1, last_of_run: 1'b1,
                        end_of_stream: last_q};
          ram_we    = 1'b1;
          ram_wdata = lit_q;
          wp_d      = wp_q + 1'b1;
          tok_done  = 1'b1;
        end
      end
      ST_RD: begin
        ram_re  = 1'b1;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          emit      = 1'b1;
          res_d     = '{data: ram_rdata, byte_valid: 1'b1,
                        last_of_run: (cnt_q == 6'd1),
                        end_of_stream: last_q && (cnt_q == 6'd1)};
          ram_we    = 1'b1;
          ram_wdata = ram_rdata;
          wp_d      = wp_q + 1'b1;
          if (cnt_q == 6'd1) begin
            tok_done = 1'b1;
          end else begin
            cnt_d   = cnt_q - 6'd1;
            src_d   = src_q + 1'b1;
            state_d = ST_RD;
          end
        end
      end
      ST_END: begin
        if (out_free) begin
          emit     = 1'b1;
          res_d    = '{data: 8'h00, byte_valid: 1'b0, last_of_run: 1'b1,
                       end_of_stream: 1'b1};
          tok_done = 1'b1;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase

    // Close the token: drop the stream on its last item, else advance flags
    if (tok_done) begin
      if (last_q) begin
        wp_d     = START_POS;
        fs_d     = '0;
        phase_d  = PH_FLAG;
        ofs_lo_d = 8'h00;
        clr_d    = '0;
        state_d  = ST_CLEAR;
      end else begin
        fs_d    = fs_shift;
        phase_d = nt_phase;
        state_d = ST_IDLE;
      end
    end

    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      phase_q     <= PH_FLAG;
      wp_q        <= START_POS;
      clr_q       <= '0;
      fs_q        <= '0;
      ofs_lo_q    <= 8'h00;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      wp_q        <= wp_d;
      clr_q       <= clr_d;
      fs_q        <= fs_d;
      ofs_lo_q    <= ofs_lo_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    src_q <= src_d;
    lit_q <= lit_d;
    cnt_q <= cnt_d;
    res_q <= res_d;
  end

  assign out_valid_o     = out_valid_q;
  assign out_byte_o      = res_q.data;
  assign byte_valid_o    = res_q.byte_valid;
  assign last_of_run_o   = res_q.last_of_run;
  assign end_of_stream_o = res_q.end_of_stream;

  a_clear_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLEAR |-> wp_q == START_POS && phase_q == PH_FLAG && !in_ready_o)
    else $error("clearing pass entered without stream state reset");

  a_copy_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT |-> cnt_q != 6'd0)
    else $error("copy byte emitted with zero count");

  a_end_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !byte_valid_o |->
      end_of_stream_o && last_of_run_o && (out_byte_o == 8'h00))
    else $error("bare marker item is not a clean end of stream");

  a_eos_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && end_of_stream_o |-> last_of_run_o)
    else $error("end of stream on an item that does not close its run");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_byte_o))
    else $error("output register overwritten while stalled");

endmodule

@@ tb/descramble_lzss_decoder_test.sv @@
// Self-checking testbench for descramble_lzss_decoder: directed token table, then random streams.
// Uses types and constants from dlz_pkg; its own model predicts results but for typed table rows.
module descramble_lzss_decoder_test;
  timeunit 1ns;
  timeprecision 1ps;
  import dlz_pkg::*;

  localparam int unsigned RANDOM_ITEMS    = 230;
  localparam int unsigned IDLE_PCT        = 23;
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam int unsigned SETTLE_CYCLES   = 8;
  localparam int unsigned DRAIN_CYCLES    = 100;
  localparam int unsigned CYCLE_LIMIT     = 5_000_000;

  typedef enum logic [1:0] {
    ROW_KEY,
    ROW_TOKEN,
    ROW_RAW
  } row_kind_e;

  // ROW_TOKEN values are plain tokens, scrambled with the current key when sent
  typedef struct packed {
    row_kind_e   kind;
    logic [31:0] value;
    logic        last;
    logic        typed;
    result_t     want;
  } stim_row_t;

  typedef struct packed {
    logic       raw;
    logic [7:0] value;
  } plan_item_t;

  localparam result_t NO_RESULT = '0;
  localparam result_t END_MARK  = '{8'h00, 1'b0, 1'b1, 1'b1};

  localparam int N_ROWS = 28;
  localparam stim_row_t DIRECTED [N_ROWS] = '{
    '{ROW_KEY,   32'h0000_0000, 1'b0, 1'b0, NO_RESULT},
    // literal first, then references reaching back over the start position
    '{ROW_TOKEN, 32'h0000_0001, 1'b0, 1'b0, NO_RESULT},
    '{ROW_TOKEN, 32'h0000_00ff, 1'b0, 1'b1, '{8'hff, 1'b1, 1'b1, 1'b0}},
    '{ROW_TOKEN, 32'h0000_0000, 1'b0, 1'b0, NO_RESULT},
    '{ROW_TOKEN, 32'h0000_0000, 1'b0, 1'b0, NO_RESULT},
    '{ROW_TOKEN, 32'h0000_00df, 1'b0, 1'b0, NO_RESULT},
    '{ROW_TOKEN, 32'h0000_00ff, 1'b0, 1'b0, NO_RESULT},
    // stream ends on half a reference
    '{ROW_TOKEN, 32'h0000_0010, 1'b1, 1'b1, END_MARK},
    // stream ends on a bare flag byte
    '{ROW_TOKEN, 32'h0000_0000, 1'b1, 1'b1, END_MARK},
    '{ROW_KEY,   32'hffff_ffff, 1'b0, 1'b0, NO_RESULT},
    '{ROW_RAW,   32'h0000_0000, 1'b1, 1'b1, END_MARK},
    '{ROW_RAW,   32'h0000_00ff, 1'b1, 1'b1, END_MARK},
    '{ROW_TOKEN, 32'h0000_00aa, 1'b0, 1'b0, NO_RESULT},
    '{ROW_TOKEN, 32'h0000_0020, 1'b0, 1'b0, NO_RESULT},
    '{ROW_TOKEN, 32'h0000_00e4, 1'b0, 1'b0, NO_RESULT},
    '{ROW_TOKEN, 32'h0000_005a, 1'b0, 1'b1, '{8'h5a, 1'b1, 1'b1, 1'b0}},
    '{ROW_TOKEN, 32'h0000_00e0, 1'b0, 1'b0, NO_RESULT},
    '{ROW_TOKEN, 32'h0000_00e2, 1'b0, 1'b0, NO_RESULT},
    // new key in the middle of a stream, largest rotate
    '{ROW_KEY,   32'h0040_0000, 1'b0, 1'b0, NO_RESULT},
    '{ROW_TOKEN, 32'h0000_003c, 1'b0, 1'b1, '{8'h3c, 1'b1, 1'b1, 1'b0}},
    '{ROW_TOKEN, 32'h0000_00e5, 1'b0, 1'b0, NO_RESULT},
    '{ROW_TOKEN, 32'h0000_00e1, 1'b0, 1'b0, NO_RESULT},
    '{ROW_TOKEN, 32'h0000_0077, 1'b1, 1'b1, '{8'h77, 1'b1, 1'b1, 1'b1}},
    '{ROW_KEY,   32'h9e37_79b9, 1'b0, 1'b0, NO_RESULT},
    // longest copy, wrapping past the top of the window
    '{ROW_TOKEN, 32'h0000_00fe, 1'b0, 1'b0, NO_RESULT},
    '{ROW_TOKEN, 32'h0000_00f0, 1'b0, 1'b0, NO_RESULT},
    '{ROW_TOKEN, 32'h0000_00ff, 1'b0, 1'b0, NO_RESULT},
    '{ROW_TOKEN, 32'h0000_0000, 1'b1, 1'b1, '{8'h00, 1'b1, 1'b1, 1'b1}}
  };

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [31:0] cfg_key_i   = '0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic [7:0]  in_byte_i   = '0;
  logic        last_byte_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  out_byte_o;
  logic        byte_valid_o;
  logic        last_of_run_o;
  logic        end_of_stream_o;

  // decoder model state
  logic [31:0]       key_q = '0;
  logic [7:0]        history [WIN_DEPTH];
  logic [WIN_AW-1:0] wr_pos;
  logic [8:0]        flag_bits;
  phase_e            phase;
  logic [7:0]        ofs_low;
  result_t           step_out [$];
  result_t           decoded_q [$];
  plan_item_t        plan [$];

  int unsigned mismatches    = 0;
  int unsigned items_sent    = 0;
  int unsigned cycle_count   = 0;
  logic        calm          = 1'b0;
  logic        hold_off_req  = 1'b0;
  logic        hold_off_done = 1'b0;

  descramble_lzss_decoder dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_key_i      (cfg_key_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .in_byte_i      (in_byte_i),
    .last_byte_i    (last_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_byte_o     (out_byte_o),
    .byte_valid_o   (byte_valid_o),
    .last_of_run_o  (last_of_run_o),
    .end_of_stream_o(end_of_stream_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic void restart_stream();
    foreach (history[i]) history[i] = 8'h00;
    wr_pos    = START_POS;
    flag_bits = '0;
    phase     = PH_FLAG;
    ofs_low   = '0;
  endfunction

  function automatic logic [7:0] xor_byte();
    return 8'((key_q >> 24) + (key_q >> 3));
  endfunction

  function automatic int unsigned rot_amount();
    return (key_q >> 20) % 5 + 1;
  endfunction

  function automatic logic [7:0] unscramble(logic [7:0] b);
    logic [7:0] t;
    t = (b - SCRAMBLE_BIAS) ^ xor_byte();
    return 8'({t, t} >> rot_amount());
  endfunction

  function automatic logic [7:0] scramble(logic [7:0] u);
    logic [7:0] t;
    t = 8'({u, u} >> (8 - rot_amount()));
    return (t ^ xor_byte()) + SCRAMBLE_BIAS;
  endfunction

  function automatic void emit_byte(logic [7:0] v);
    step_out.push_back('{v, 1'b1, 1'b0, 1'b0});
    history[wr_pos] = v;
    wr_pos = wr_pos + 1'b1;
  endfunction

  function automatic void next_flag();
    flag_bits = flag_bits >> 1;
    if (flag_bits <= 9'd1) phase = PH_FLAG;
    else phase = flag_bits[0] ? PH_LIT : PH_OFS_LO;
  endfunction

  // Decode one scrambled byte into step_out
  function automatic void decode_byte(logic [7:0] raw, logic last);
    logic [7:0]        u;
    logic [WIN_AW-1:0] src;
    int unsigned       len;
    int                n;
    step_out.delete();
    u = unscramble(raw);
    case (phase)
      PH_FLAG: begin
        flag_bits = {1'b1, u};
        phase = u[0] ? PH_LIT : PH_OFS_LO;
      end
      PH_LIT: begin
        emit_byte(u);
        next_flag();
      end
      PH_OFS_LO: begin
        ofs_low = u;
        phase = PH_OFS_HI;
      end
      default: begin
        src = {u[7:5], ofs_low};
        len = u[4:0] + COPY_BIAS;
        // read then write each byte so overlapping copies repeat fresh output
        for (int i = 0; i < len; i++) begin
          emit_byte(history[src]);
          src = src + 1'b1;
        end
        next_flag();
      end
    endcase
    if (last) begin
      if (step_out.size() == 0) step_out.push_back(END_MARK);
      n = step_out.size() - 1;
      step_out[n].end_of_stream = 1'b1;
      restart_stream();
    end
    if (step_out.size() != 0) begin
      n = step_out.size() - 1;
      step_out[n].last_of_run = 1'b1;
    end
  endfunction

  function automatic logic [31:0] pick_key();
    case ($urandom_range(3))
      0: return '0;
      1: return '1;
      default: return $urandom();
    endcase
  endfunction

  // Build one flag group with its tokens, or a short burst of noise
  function automatic void plan_group();
    logic [7:0]        flags;
    logic [WIN_AW-1:0] pos;
    logic [WIN_AW-1:0] src;
    logic [4:0]        len_code;
    plan.delete();
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(5, 1)) plan.push_back('{1'b1, 8'($urandom())});
      return;
    end
    pos   = wr_pos;
    flags = 8'($urandom());
    plan.push_back('{1'b0, flags});
    for (int bit_i = 0; bit_i < 8; bit_i++) begin
      if (flags[bit_i]) begin
        plan.push_back('{1'b0, 8'($urandom())});
        pos = pos + 1'b1;
      end else begin
        // mostly point just behind the write position
        if ($urandom_range(9) < 7) src = pos - WIN_AW'($urandom_range(40, 1));
        else src = WIN_AW'($urandom());
        len_code = ($urandom_range(4) == 0) ? 5'($urandom()) : 5'($urandom_range(7));
        plan.push_back('{1'b0, src[7:0]});
        plan.push_back('{1'b0, {src[10:8], len_code}});
        pos = pos + len_code + COPY_BIAS;
      end
    end
  endfunction

  task automatic send_item(logic [7:0] b, logic last, logic typed, result_t want);
    if (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    in_byte_i   <= b;
    last_byte_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
    decode_byte(b, last);
    if (typed) decoded_q.push_back(want);
    else foreach (step_out[i]) decoded_q.push_back(step_out[i]);
  endtask

  // Write the key once the decoder has drained
  task automatic write_key(logic [31:0] k);
    in_valid_i <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_key_i   <= k;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    key_q = k;
  endtask

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h got %h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{out_byte_o, byte_valid_o, last_of_run_o, end_of_stream_o};
      if (decoded_q.size() == 0) begin
        $display("%0t: result %h with nothing expected", $time, got);
        mismatches++;
      end else begin
        want = decoded_q.pop_front();
        check_field("out_byte", want.data, got.data);
        check_field("byte_valid", 8'(want.byte_valid), 8'(got.byte_valid));
        check_field("last_of_run", 8'(want.last_of_run), 8'(got.last_of_run));
        check_field("end_of_stream", 8'(want.end_of_stream), 8'(got.end_of_stream));
      end
    end
  end

  // Receiver: random stalls, one long hold-off when asked
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_off_req && !hold_off_done) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
        hold_off_done = 1'b1;
      end else begin
        out_ready_i <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("%0t: timed out with %0d results outstanding", $time, decoded_q.size());
    $display("descramble_lzss_decoder_test NOT OK");
    $finish;
  end

  initial begin
    int unsigned n_groups;
    int unsigned keep;
    int unsigned first_random;
    logic [7:0]  raw_b;
    restart_stream();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int r = 0; r < N_ROWS; r++) begin
      if (DIRECTED[r].kind == ROW_KEY) begin
        write_key(DIRECTED[r].value);
      end else begin
        raw_b = (DIRECTED[r].kind == ROW_RAW) ? DIRECTED[r].value[7:0]
                                               : scramble(DIRECTED[r].value[7:0]);
        send_item(raw_b, DIRECTED[r].last, DIRECTED[r].typed, DIRECTED[r].want);
      end
    end

    hold_off_req = 1'b1;
    first_random = items_sent;
    while (items_sent - first_random < RANDOM_ITEMS) begin
      n_groups = $urandom_range(4, 1);
      for (int g = 0; g < n_groups; g++) begin
        calm = (items_sent - first_random) inside {[110:170]};
        plan_group();
        // cut the final group short now and then so the stream ends mid-token
        if (g == n_groups - 1 && $urandom_range(3) == 0) begin
          keep = $urandom_range(plan.size(), 1);
          while (plan.size() > keep) void'(plan.pop_back());
        end
        foreach (plan[i]) begin
          raw_b = plan[i].raw ? plan[i].value : scramble(plan[i].value);
          send_item(raw_b, (g == n_groups - 1) && (i == plan.size() - 1), 1'b0, NO_RESULT);
        end
        if (g != n_groups - 1 && $urandom_range(9) == 0) write_key(pick_key());
      end
      if ($urandom_range(2) == 0) write_key(pick_key());
    end

    in_valid_i <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) $display("descramble_lzss_decoder_test OK");
    else $display("descramble_lzss_decoder_test NOT OK");
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/dlz_pkg.sv
hw/rtl/dlz_ram.sv
hw/rtl/dlz_unscramble.sv
hw/rtl/descramble_lzss_decoder.sv
tb/descramble_lzss_decoder_test.sv
